FILE: design/scc_pkg.sv
// Shared constants and item types for the strongly connected components block.
package scc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 8192;

    localparam int VW  = 10;                  // vertex / component field width
    localparam int NCW = 11;                  // node count width
    localparam int EW  = $clog2(MAX_EDGES);   // edge index width
    localparam int ECW = EW + 1;              // edge count width
    localparam int BW  = $clog2(MAX_NODES + 1);

    typedef struct packed {
        logic          func;
        logic [VW-1:0] source_vertex;
        logic [VW-1:0] dest_vertex;
    } t_in;

    typedef struct packed {
        logic          result_valid;
        logic [VW-1:0] vertex;
        logic [VW-1:0] component;
        logic          component_end;
        logic          list_end;
        logic          edge_overflow;
    } t_out;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [VW-1:0] component;
        logic          last;
    } t_res;

endpackage

FILE: design/strongly_connected_components.sv
// Tarjan SCC engine: edge store, forward-star sort and iterative search over memories.
//
// Usage: an item is taken when start is high and busy is low. func 0 stores one edge
// (source_vertex -> dest_vertex); edges beyond MAX_EDGES are dropped and
// set the sticky edge_overflow flag. func 1 pulls one result vertex.
// The first pull after loading sorts the edges by source and runs the depth-first
// search; busy stays high for that whole run. The length of the sort and the search is
// set by the single read port and registered read of each state memory, one access
// per step of the sequencer. After the search every pull is answered in the cycle
// after it is taken, and pulls may follow each other every cycle.
// Each result sits on o_out for one cycle with o_strobe high; the receiver cannot
// stall it. An edge item after results have been given starts a new graph.
// Configuration: node_count is written through i_cfg_valid/o_cfg_ready (always ready)
// and is sampled when a search starts.
// Reset clears the control state: loading phase, no edges, node_count 1024.
// No clearing pass is needed at reset; per-search tables are swept before each sort.
module strongly_connected_components (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  scc_pkg::t_in               i_in,
    output logic                       o_strobe,
    output scc_pkg::t_out              o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [scc_pkg::NCW-1:0]    i_cfg_data
);

    localparam int VW  = scc_pkg::VW;
    localparam int NCW = scc_pkg::NCW;
    localparam int EW  = scc_pkg::EW;
    localparam int ECW = scc_pkg::ECW;
    localparam int BW  = scc_pkg::BW;
    localparam int MAXN = scc_pkg::MAX_NODES;
    localparam int MAXE = scc_pkg::MAX_EDGES;

    localparam logic [1:0] ST_UNV  = 2'd0;
    localparam logic [1:0] ST_ON   = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CLR   = 5'd1;
    localparam logic [4:0] S_CNT_A = 5'd2;
    localparam logic [4:0] S_CNT_B = 5'd3;
    localparam logic [4:0] S_CNT_C = 5'd4;
    localparam logic [4:0] S_PFX_A = 5'd5;
    localparam logic [4:0] S_PFX_B = 5'd6;
    localparam logic [4:0] S_SCT_A = 5'd7;
    localparam logic [4:0] S_SCT_B = 5'd8;
    localparam logic [4:0] S_SCT_C = 5'd9;
    localparam logic [4:0] S_ROOT_A = 5'd10;
    localparam logic [4:0] S_ROOT_B = 5'd11;
    localparam logic [4:0] S_POP   = 5'd12;
    localparam logic [4:0] S_POPV  = 5'd13;
    localparam logic [4:0] S_LD    = 5'd14;
    localparam logic [4:0] S_E0    = 5'd15;
    localparam logic [4:0] S_E1    = 5'd16;
    localparam logic [4:0] S_E2    = 5'd17;
    localparam logic [4:0] S_E3    = 5'd18;
    localparam logic [4:0] S_PUSH1 = 5'd19;
    localparam logic [4:0] S_PUSH2 = 5'd20;
    localparam logic [4:0] S_FIN0  = 5'd21;
    localparam logic [4:0] S_FIN1  = 5'd22;
    localparam logic [4:0] S_FIN2  = 5'd23;
    localparam logic [4:0] S_CHK   = 5'd24;
    localparam logic [4:0] S_EM0   = 5'd25;
    localparam logic [4:0] S_EM1   = 5'd26;
    localparam logic [4:0] S_DONE  = 5'd27;

    function automatic logic [VW-1:0] clamp_vertex(input logic [VW-1:0] v,
                                                   input logic [NCW-1:0] n);
        logic [NCW-1:0] nm1;
        nm1 = n - NCW'(1);
        clamp_vertex = ({1'b0, v} < n) ? v : nm1[VW-1:0];
    endfunction

    // control registers
    logic [4:0]     r_state;
    logic           r_phase;      // 1: results are being given
    logic [ECW-1:0] r_etotal;
    logic           r_ovf;
    logic [NCW-1:0] r_node_cnt;
    logic [NCW-1:0] r_n;
    logic [NCW-1:0] r_rp;
    logic [NCW-1:0] r_rc;
    logic           r_out_pend;
    logic           r_out_hit;
    logic           r_out_last;

    // sequencer working registers
    logic [ECW-1:0] r_i;
    logic [ECW-1:0] r_acc;
    logic [VW-1:0]  r_s;
    logic [NCW-1:0] r_root;
    logic [NCW-1:0] r_ff;
    logic [NCW-1:0] r_comp;
    logic [NCW-1:0] r_top;
    logic [NCW-1:0] r_btop;
    logic [VW-1:0]  r_v;
    logic [VW-1:0]  r_u;
    logic [VW-1:0]  r_p;
    logic [ECW-1:0] r_cur;
    logic [ECW-1:0] r_end;
    logic [VW-1:0]  r_lowv;
    logic [VW-1:0]  r_disc;

    // memories
    logic [VW-1:0]  mem_src  [MAXE];
    logic [VW-1:0]  mem_dst  [MAXE];
    logic [EW-1:0]  mem_sort [MAXE];
    logic [ECW-1:0] mem_bkt  [MAXN+1];
    logic [ECW-1:0] mem_cur  [MAXN];
    logic [ECW-1:0] mem_end  [MAXN];
    logic [VW-1:0]  mem_disc [MAXN];
    logic [VW-1:0]  mem_low  [MAXN];
    logic [1:0]     mem_stat [MAXN];
    logic [VW-1:0]  mem_dfs  [MAXN];
    logic [VW-1:0]  mem_cstk [MAXN];
    scc_pkg::t_res  mem_res  [MAXN];

    logic [VW-1:0]  r_src_rd, r_dst_rd, r_disc_rd, r_low_rd, r_dfs_rd, r_cstk_rd;
    logic [EW-1:0]  r_sort_rd;
    logic [ECW-1:0] r_bkt_rd, r_cur_rd, r_end_rd;
    logic [1:0]     r_stat_rd;
    scc_pkg::t_res  r_res_rd;

    logic           src_we;
    logic [EW-1:0]  src_wa;
    logic           sort_we;
    logic [EW-1:0]  sort_wa;
    logic           bkt_we;
    logic [BW-1:0]  bkt_wa, bkt_ra;
    logic [ECW-1:0] bkt_wd;
    logic           cur_we;
    logic [VW-1:0]  cur_wa;
    logic [ECW-1:0] cur_wd;
    logic           end_we;
    logic [VW-1:0]  end_wa;
    logic           disc_we;
    logic [VW-1:0]  disc_wa;
    logic           low_we;
    logic [VW-1:0]  low_wa, low_wd, low_ra;
    logic           stat_we;
    logic [VW-1:0]  stat_wa, stat_ra;
    logic [1:0]     stat_wd;
    logic           dfs_we;
    logic [VW-1:0]  dfs_wa, dfs_wd, dfs_ra;
    logic           cstk_we;
    logic [VW-1:0]  cstk_wa, cstk_wd, cstk_ra;
    logic           res_we;
    scc_pkg::t_res  res_wd;

    logic           accept;
    logic           do_read;
    logic [VW-1:0]  src_cl;
    logic [VW-1:0]  dst_cl;
    logic [ECW-1:0] pfx_sum;
    logic [ECW-1:0] bkt_dec;
    logic [NCW-1:0] n_clamped;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign do_read     = (accept && i_in.func && r_phase) || (r_state == S_DONE);
    assign src_cl      = clamp_vertex(r_src_rd, r_n);
    assign dst_cl      = clamp_vertex(r_dst_rd, r_n);
    assign pfx_sum     = r_acc + r_bkt_rd;
    assign bkt_dec     = r_bkt_rd - ECW'(1);

    always_comb begin
        priority if (r_node_cnt == '0) begin
            n_clamped = NCW'(1);
        end else if (r_node_cnt > NCW'(MAXN)) begin
            n_clamped = NCW'(MAXN);
        end else begin
            n_clamped = r_node_cnt;
        end
    end

    // memory port steering
    always_comb begin
        src_we  = accept && !i_in.func && (r_phase || r_etotal < ECW'(MAXE));
        src_wa  = r_phase ? '0 : r_etotal[EW-1:0];
        sort_we = 1'b0;
        sort_wa = bkt_dec[EW-1:0];
        bkt_we  = 1'b0;
        bkt_wa  = r_i[BW-1:0];
        bkt_wd  = '0;
        bkt_ra  = BW'({1'b0, src_cl}) + BW'(1);
        cur_we  = 1'b0;
        cur_wa  = r_i[VW-1:0];
        cur_wd  = '0;
        end_we  = 1'b0;
        end_wa  = VW'(r_i - ECW'(1));
        disc_we = 1'b0;
        disc_wa = r_u;
        low_we  = 1'b0;
        low_wa  = r_v;
        low_wd  = r_lowv;
        low_ra  = r_dfs_rd;
        stat_we = 1'b0;
        stat_wa = r_i[VW-1:0];
        stat_wd = ST_UNV;
        stat_ra = r_root[VW-1:0];
        dfs_we  = 1'b0;
        dfs_wa  = '0;
        dfs_wd  = r_root[VW-1:0];
        dfs_ra  = VW'(r_top - NCW'(1));
        cstk_we = 1'b0;
        cstk_wa = '0;
        cstk_wd = r_root[VW-1:0];
        cstk_ra = VW'(r_btop - NCW'(1));
        res_we  = 1'b0;
        res_wd  = '{vertex: r_cstk_rd, component: r_comp[VW-1:0],
                    last: (r_cstk_rd == r_v)};
        unique case (r_state)
            S_CLR: begin
                bkt_we  = 1'b1;
                stat_we = (r_i < ECW'(MAXN));
                cur_we  = (r_i == '0);
            end
            S_CNT_C: begin
                bkt_we = 1'b1;
                bkt_wa = BW'({1'b0, r_s}) + BW'(1);
                bkt_wd = r_bkt_rd + ECW'(1);
            end
            S_PFX_A: begin
                bkt_ra = r_i[BW-1:0];
            end
            S_PFX_B: begin
                bkt_we = 1'b1;
                bkt_wd = pfx_sum;
                end_we = 1'b1;
                cur_we = (r_i < ECW'(r_n));
                cur_wd = pfx_sum;
            end
            S_SCT_C: begin
                bkt_we  = 1'b1;
                bkt_wa  = BW'({1'b0, r_s}) + BW'(1);
                bkt_wd  = bkt_dec;
                sort_we = 1'b1;
            end
            S_ROOT_B: begin
                if (r_stat_rd == ST_UNV) begin
                    dfs_we  = 1'b1;
                    cstk_we = 1'b1;
                    disc_we = 1'b1;
                    disc_wa = r_root[VW-1:0];
                    low_we  = 1'b1;
                    low_wa  = r_root[VW-1:0];
                    low_wd  = r_ff[VW-1:0];
                    stat_we = 1'b1;
                    stat_wa = r_root[VW-1:0];
                    stat_wd = ST_ON;
                end
            end
            S_E2: begin
                stat_ra = dst_cl;
                low_ra  = dst_cl;
            end
            S_PUSH1: begin
                low_we = 1'b1;
                cur_we = 1'b1;
                cur_wa = r_v;
                cur_wd = r_cur + ECW'(1);
                dfs_we = 1'b1;
                dfs_wa = VW'(r_top + NCW'(1));
                dfs_wd = r_u;
            end
            S_PUSH2: begin
                low_we  = 1'b1;
                low_wa  = r_u;
                low_wd  = r_ff[VW-1:0];
                disc_we = 1'b1;
                stat_we = 1'b1;
                stat_wa = r_u;
                stat_wd = ST_ON;
                cstk_we = 1'b1;
                cstk_wa = r_btop[VW-1:0];
                cstk_wd = r_u;
            end
            S_FIN0: begin
                low_we = 1'b1;
            end
            S_FIN2: begin
                low_we = (r_lowv < r_low_rd);
                low_wa = r_p;
            end
            S_EM1: begin
                res_we  = 1'b1;
                stat_we = 1'b1;
                stat_wa = r_cstk_rd;
                stat_wd = ST_DONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (src_we) begin
            mem_src[src_wa] <= i_in.source_vertex;
            mem_dst[src_wa] <= i_in.dest_vertex;
        end
        r_src_rd <= mem_src[r_i[EW-1:0]];
        r_dst_rd <= mem_dst[r_sort_rd];
    end

    always_ff @(posedge i_clk) begin
        if (sort_we) begin
            mem_sort[sort_wa] <= r_i[EW-1:0];
        end
        r_sort_rd <= mem_sort[r_cur[EW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            mem_bkt[bkt_wa] <= bkt_wd;
        end
        r_bkt_rd <= mem_bkt[bkt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cur_we) begin
            mem_cur[cur_wa] <= cur_wd;
        end
        if (end_we) begin
            mem_end[end_wa] <= pfx_sum;
        end
        if (disc_we) begin
            mem_disc[disc_wa] <= r_ff[VW-1:0];
        end
        r_cur_rd  <= mem_cur[r_dfs_rd];
        r_end_rd  <= mem_end[r_dfs_rd];
        r_disc_rd <= mem_disc[r_dfs_rd];
    end

    always_ff @(posedge i_clk) begin
        if (low_we) begin
            mem_low[low_wa] <= low_wd;
        end
        r_low_rd <= mem_low[low_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stat_we) begin
            mem_stat[stat_wa] <= stat_wd;
        end
        r_stat_rd <= mem_stat[stat_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dfs_we) begin
            mem_dfs[dfs_wa] <= dfs_wd;
        end
        r_dfs_rd <= mem_dfs[dfs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cstk_we) begin
            mem_cstk[cstk_wa] <= cstk_wd;
        end
        r_cstk_rd <= mem_cstk[cstk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            mem_res[r_rc[VW-1:0]] <= res_wd;
        end
        r_res_rd <= mem_res[r_rp[VW-1:0]];
    end

    // payload-only working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CNT_B, S_SCT_B: r_s <= src_cl;
            S_POPV: r_v <= r_dfs_rd;
            S_E2: r_u <= dst_cl;
            S_FIN1: r_p <= r_dfs_rd;
            default: begin
            end
        endcase
        if (r_state == S_LD) begin
            r_end  <= r_end_rd;
            r_disc <= r_disc_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= 1'b0;
            r_etotal   <= '0;
            r_ovf      <= 1'b0;
            r_node_cnt <= NCW'(MAXN);
            r_n        <= NCW'(MAXN);
            r_rp       <= '0;
            r_rc       <= '0;
            r_out_pend <= 1'b0;
            r_out_hit  <= 1'b0;
            r_out_last <= 1'b0;
            r_i        <= '0;
            r_acc      <= '0;
            r_root     <= '0;
            r_ff       <= '0;
            r_comp     <= '0;
            r_top      <= '0;
            r_btop     <= '0;
            r_cur      <= '0;
            r_lowv     <= '0;
        end else begin
            r_out_pend <= 1'b0;
            if (i_cfg_valid) begin
                r_node_cnt <= i_cfg_data;
            end
            if (do_read) begin
                r_out_pend <= 1'b1;
                r_out_hit  <= (r_rp < r_rc);
                r_out_last <= ((r_rp + NCW'(1)) == r_rc);
                if (r_rp < r_rc) begin
                    r_rp <= r_rp + NCW'(1);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!i_in.func) begin
                            if (r_phase) begin
                                r_phase  <= 1'b0;
                                r_ovf    <= 1'b0;
                                r_etotal <= ECW'(1);
                                r_rp     <= '0;
                            end else if (r_etotal < ECW'(MAXE)) begin
                                r_etotal <= r_etotal + ECW'(1);
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end else if (!r_phase) begin
                            r_n     <= n_clamped;
                            r_i     <= '0;
                            r_rp    <= '0;
                            r_state <= S_CLR;
                        end
                    end
                end
                S_CLR: begin
                    if (r_i == ECW'(r_n)) begin
                        r_acc <= '0;
                        if (r_etotal == '0) begin
                            r_i     <= ECW'(1);
                            r_state <= S_PFX_A;
                        end else begin
                            r_i     <= '0;
                            r_state <= S_CNT_A;
                        end
                    end else begin
                        r_i <= r_i + ECW'(1);
                    end
                end
                S_CNT_A: r_state <= S_CNT_B;
                S_CNT_B: r_state <= S_CNT_C;
                S_CNT_C: begin
                    if (r_i + ECW'(1) == r_etotal) begin
                        r_i     <= ECW'(1);
                        r_state <= S_PFX_A;
                    end else begin
                        r_i     <= r_i + ECW'(1);
                        r_state <= S_CNT_A;
                    end
                end
                S_PFX_A: r_state <= S_PFX_B;
                S_PFX_B: begin
                    r_acc <= pfx_sum;
                    if (r_i == ECW'(r_n)) begin
                        r_i <= '0;
                        if (r_etotal == '0) begin
                            r_root  <= '0;
                            r_ff    <= '0;
                            r_comp  <= '0;
                            r_rc    <= '0;
                            r_state <= S_ROOT_A;
                        end else begin
                            r_state <= S_SCT_A;
                        end
                    end else begin
                        r_i     <= r_i + ECW'(1);
                        r_state <= S_PFX_A;
                    end
                end
                S_SCT_A: r_state <= S_SCT_B;
                S_SCT_B: r_state <= S_SCT_C;
                S_SCT_C: begin
                    if (r_i + ECW'(1) == r_etotal) begin
                        r_root  <= '0;
                        r_ff    <= '0;
                        r_comp  <= '0;
                        r_rc    <= '0;
                        r_state <= S_ROOT_A;
                    end else begin
                        r_i     <= r_i + ECW'(1);
                        r_state <= S_SCT_A;
                    end
                end
                S_ROOT_A: r_state <= S_ROOT_B;
                S_ROOT_B: begin
                    if (r_stat_rd == ST_UNV) begin
                        r_ff    <= r_ff + NCW'(1);
                        r_top   <= NCW'(1);
                        r_btop  <= NCW'(1);
                        r_state <= S_POP;
                    end else if (r_root + NCW'(1) == r_n) begin
                        r_state <= S_DONE;
                    end else begin
                        r_root  <= r_root + NCW'(1);
                        r_state <= S_ROOT_A;
                    end
                end
                S_POP: begin
                    if (r_top == '0) begin
                        if (r_root + NCW'(1) == r_n) begin
                            r_state <= S_DONE;
                        end else begin
                            r_root  <= r_root + NCW'(1);
                            r_state <= S_ROOT_A;
                        end
                    end else begin
                        r_top   <= r_top - NCW'(1);
                        r_state <= S_POPV;
                    end
                end
                S_POPV: r_state <= S_LD;
                S_LD: begin
                    r_cur   <= r_cur_rd;
                    r_lowv  <= r_low_rd;
                    r_state <= S_E0;
                end
                S_E0: r_state <= (r_cur < r_end) ? S_E1 : S_FIN0;
                S_E1: r_state <= S_E2;
                S_E2: r_state <= S_E3;
                S_E3: begin
                    if (r_stat_rd == ST_UNV) begin
                        r_state <= S_PUSH1;
                    end else begin
                        r_cur <= r_cur + ECW'(1);
                        if (r_stat_rd == ST_ON && r_low_rd < r_lowv) begin
                            r_lowv <= r_low_rd;
                        end
                        r_state <= S_E0;
                    end
                end
                S_PUSH1: begin
                    r_top   <= r_top + NCW'(2);
                    r_state <= S_PUSH2;
                end
                S_PUSH2: begin
                    r_ff    <= r_ff + NCW'(1);
                    r_btop  <= r_btop + NCW'(1);
                    r_state <= S_POP;
                end
                S_FIN0: r_state <= (r_top != '0) ? S_FIN1 : S_CHK;
                S_FIN1: r_state <= S_FIN2;
                S_FIN2: r_state <= S_CHK;
                S_CHK: r_state <= (r_lowv == r_disc) ? S_EM0 : S_POP;
                S_EM0: begin
                    r_btop  <= r_btop - NCW'(1);
                    r_state <= S_EM1;
                end
                S_EM1: begin
                    r_rc <= r_rc + NCW'(1);
                    if (r_cstk_rd != r_v && r_btop != '0) begin
                        r_state <= S_EM0;
                    end else begin
                        r_comp  <= r_comp + NCW'(1);
                        r_state <= S_POP;
                    end
                end
                S_DONE: begin
                    r_phase <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe = r_out_pend;
    always_comb begin
        o_out.result_valid  = r_out_hit;
        o_out.vertex        = r_out_hit ? r_res_rd.vertex : '0;
        o_out.component     = r_out_hit ? r_res_rd.component : '0;
        o_out.component_end = r_out_hit && r_res_rd.last;
        o_out.list_end      = r_out_hit && r_out_last;
        o_out.edge_overflow = r_ovf;
    end

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DONE) || $past(start && !busy && i_in.func))
        else $error("result strobe without a pull");

    a_dfs_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_top <= r_n)
        else $error("search stack deeper than vertex count");

    a_cstk_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_btop <= r_n)
        else $error("component stack deeper than vertex count");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM0) |-> r_btop != '0)
        else $error("component pop from empty stack");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_rc || !r_phase)
        else $error("read pointer past result count");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the Tarjan strongly connected components block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 20;
    localparam int HANG_LIMIT    = 1000000;
    localparam int TAIL_CYCLES   = 50;
    localparam int MAX_NODES     = scc_pkg::MAX_NODES;
    localparam int MAX_EDGES     = scc_pkg::MAX_EDGES;
    localparam int NCW           = scc_pkg::NCW;
    localparam int VW            = scc_pkg::VW;

    typedef enum logic [1:0] {CMD_ITEM, CMD_CFG, CMD_DRAIN, CMD_MODE} t_cmd_kind;
    typedef struct {
        t_cmd_kind     kind;
        scc_pkg::t_in  item;
        int unsigned   arg;
    } t_cmd;

    typedef enum logic [1:0] {V_UNSEEN, V_ON_STACK, V_DONE} t_visit;
    typedef enum logic {PH_LOADING, PH_RESULTS} t_phase;
    localparam logic FN_EDGE = 1'b0;
    localparam logic FN_PULL = 1'b1;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    scc_pkg::t_in   i_in = '0;
    logic           o_strobe;
    scc_pkg::t_out  o_out;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [NCW-1:0] i_cfg_data = '0;

    strongly_connected_components u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    t_cmd          pending_cmds[$];
    scc_pkg::t_out expected_vertices[$];
    int            errors = 0;

    // graph mirror
    int unsigned e_src[MAX_EDGES];
    int unsigned e_dst[MAX_EDGES];
    int unsigned sorted_ids[MAX_EDGES];
    int unsigned bucket[MAX_NODES+1];
    int unsigned cursor[MAX_NODES];
    int unsigned edge_stop[MAX_NODES];
    int unsigned disc[MAX_NODES];
    int unsigned low[MAX_NODES];
    int unsigned dstack[MAX_NODES];
    int unsigned cstack[MAX_NODES];
    t_visit      status[MAX_NODES];
    int unsigned emit_vert[MAX_NODES];
    int unsigned emit_comp[MAX_NODES];
    bit          emit_last[MAX_NODES];
    int unsigned emit_cnt = 0;
    int unsigned edge_cnt = 0;
    int unsigned read_ptr = 0;
    t_phase      graph_phase = PH_LOADING;
    bit          dropped_edge = 1'b0;
    int unsigned node_cfg = MAX_NODES;

    function automatic int unsigned clampv(int unsigned v, int unsigned n);
        return (v < n) ? v : n - 1;
    endfunction

    task automatic find_components();
        int unsigned n, m, i, ff, comp, top, btop, v, u, id, p, w, s;
        n = node_cfg;
        if (n < 1) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        m = edge_cnt;
        ff = 0;
        comp = 0;
        for (i = 0; i <= MAX_NODES; i++) bucket[i] = 0;
        for (i = 0; i < m; i++) bucket[clampv(e_src[i], n) + 1]++;
        for (i = 1; i <= n; i++) bucket[i] += bucket[i-1];
        for (i = 0; i < n; i++) begin
            cursor[i] = bucket[i];
            edge_stop[i] = bucket[i+1];
        end
        for (i = 0; i < m; i++) begin
            s = clampv(e_src[i], n);
            bucket[s+1]--;
            sorted_ids[bucket[s+1]] = i;
        end
        for (i = 0; i < MAX_NODES; i++) status[i] = V_UNSEEN;
        emit_cnt = 0;
        for (i = 0; i < n; i++) begin
            if (status[i] != V_UNSEEN) continue;
            top = 0;
            btop = 0;
            dstack[top] = i;
            top++;
            cstack[btop] = i;
            btop++;
            disc[i] = ff;
            low[i] = ff;
            ff++;
            status[i] = V_ON_STACK;
            while (top > 0) begin
                top--;
                v = dstack[top];
                u = 0;
                while (cursor[v] < edge_stop[v]) begin
                    id = sorted_ids[cursor[v]];
                    u = clampv(e_dst[id], n);
                    if (status[u] == V_UNSEEN) break;
                    cursor[v]++;
                    if (status[u] == V_ON_STACK && low[u] < low[v]) low[v] = low[u];
                end
                if (cursor[v] == edge_stop[v]) begin
                    if (top > 0) begin
                        p = dstack[top-1];
                        if (low[v] < low[p]) low[p] = low[v];
                    end
                    if (low[v] == disc[v]) begin
                        do begin
                            btop--;
                            w = cstack[btop];
                            emit_vert[emit_cnt] = w;
                            emit_comp[emit_cnt] = comp;
                            emit_last[emit_cnt] = (w == v);
                            emit_cnt++;
                            status[w] = V_DONE;
                        end while (w != v && btop > 0);
                        comp++;
                    end
                end else begin
                    dstack[top] = v;
                    top++;
                    cursor[v]++;
                    disc[u] = ff;
                    low[u] = ff;
                    ff++;
                    status[u] = V_ON_STACK;
                    dstack[top] = u;
                    top++;
                    cstack[btop] = u;
                    btop++;
                end
            end
        end
    endtask

    task automatic track_item(scc_pkg::t_in it);
        scc_pkg::t_out r;
        if (it.func == FN_EDGE) begin
            if (graph_phase != PH_LOADING) begin
                graph_phase = PH_LOADING;
                edge_cnt = 0;
                read_ptr = 0;
                dropped_edge = 1'b0;
            end
            if (edge_cnt < MAX_EDGES) begin
                e_src[edge_cnt] = 32'(it.source_vertex);
                e_dst[edge_cnt] = 32'(it.dest_vertex);
                edge_cnt++;
            end else begin
                dropped_edge = 1'b1;
            end
        end else begin
            if (graph_phase == PH_LOADING) begin
                find_components();
                graph_phase = PH_RESULTS;
                read_ptr = 0;
            end
            r = '0;
            if (read_ptr < emit_cnt) begin
                r.result_valid  = 1'b1;
                r.vertex        = VW'(emit_vert[read_ptr]);
                r.component     = VW'(emit_comp[read_ptr]);
                r.component_end = emit_last[read_ptr];
                r.list_end      = (read_ptr + 1 == emit_cnt);
                read_ptr++;
            end
            r.edge_overflow = dropped_edge;
            expected_vertices.insert(expected_vertices.size(), r);
        end
    endtask

    // stimulus queue helpers
    task automatic add_edge(int unsigned s, int unsigned d);
        t_cmd c;
        c.kind = CMD_ITEM;
        c.item.func = FN_EDGE;
        c.item.source_vertex = VW'(s);
        c.item.dest_vertex = VW'(d);
        c.arg = 0;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic add_pulls(int unsigned k);
        t_cmd c;
        c.kind = CMD_ITEM;
        c.arg = 0;
        repeat (k) begin
            c.item.func = FN_PULL;
            c.item.source_vertex = VW'($urandom);
            c.item.dest_vertex = VW'($urandom);
            pending_cmds.insert(pending_cmds.size(), c);
        end
    endtask

    task automatic add_ctl(t_cmd_kind kind, int unsigned arg);
        t_cmd c;
        c.kind = kind;
        c.item = '0;
        c.arg = arg;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    int unsigned idle_pct = 0;
    int unsigned quiet = 0;
    always @(posedge i_clk) begin
        t_cmd c;
        logic take, nxt_start, nxt_cfg, settled;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            take = start && !busy;
            if (take) track_item(i_in);
            if (i_cfg_valid && o_cfg_ready) node_cfg = 32'(i_cfg_data);
            nxt_start = start && !take;
            nxt_cfg = i_cfg_valid && !o_cfg_ready;
            quiet = (take || o_strobe) ? 0 : quiet + 1;
            settled = (expected_vertices.size() == 0) && (quiet >= SETTLE_CYCLES);
            if (!nxt_start && !nxt_cfg && pending_cmds.size() > 0) begin
                c = pending_cmds[0];
                case (c.kind)
                    CMD_ITEM: begin
                        if ($urandom_range(0, 99) >= idle_pct) begin
                            nxt_start = 1'b1;
                            i_in <= c.item;
                            void'(pending_cmds.pop_front());
                        end
                    end
                    CMD_CFG: begin
                        if (settled) begin
                            nxt_cfg = 1'b1;
                            i_cfg_data <= NCW'(c.arg);
                            void'(pending_cmds.pop_front());
                        end
                    end
                    CMD_DRAIN: begin
                        if (settled) void'(pending_cmds.pop_front());
                    end
                    default: begin
                        idle_pct = c.arg;
                        void'(pending_cmds.pop_front());
                    end
                endcase
            end
            start <= nxt_start;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        scc_pkg::t_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_vertices.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $realtime, o_out);
                errors++;
            end else begin
                want = expected_vertices.pop_front();
                if (o_out.result_valid !== want.result_valid || o_out.vertex !== want.vertex
                    || o_out.component !== want.component
                    || o_out.component_end !== want.component_end
                    || o_out.list_end !== want.list_end
                    || o_out.edge_overflow !== want.edge_overflow) begin
                    $display("%0t: mismatch, expected %p, actual %p", $realtime, want, o_out);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    int unsigned hang = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            hang <= 0;
        end else if (hang >= HANG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            hang <= hang + 1;
        end
    end

    initial begin
        int unsigned items, n_cfg, n, m, pulls, k, r, s, d;
        // directed: no edges, every vertex alone
        add_ctl(CMD_CFG, 3);
        add_pulls(4);
        add_ctl(CMD_CFG, 1024);
        add_edge(1023, 0);
        add_edge(0, 1023);
        add_edge(1023, 1023);
        add_pulls(3);
        // cycle plus tail, one out-of-range source
        add_ctl(CMD_CFG, 4);
        add_edge(0, 1);
        add_edge(1, 2);
        add_edge(2, 0);
        add_edge(2, 3);
        add_edge(1000, 5);
        add_pulls(2);
        add_ctl(CMD_CFG, 9);      // overwritten before the next search starts
        add_pulls(4);
        add_ctl(CMD_CFG, 0);
        add_edge(0, 0);
        add_pulls(2);
        add_ctl(CMD_CFG, 2047);
        add_edge(5, 6);
        add_pulls(2);
        // full edge store, then drops
        add_ctl(CMD_CFG, 8);
        for (k = 0; k < MAX_EDGES + 8; k++) add_edge($urandom_range(0, 9), $urandom_range(0, 9));
        add_pulls(10);
        add_ctl(CMD_DRAIN, 0);
        items = 0;
        while (items < 1850) begin
            case ((items / 300) % 3)
                0: add_ctl(CMD_MODE, 0);
                1: add_ctl(CMD_MODE, 76);
                default: add_ctl(CMD_MODE, 20);
            endcase
            r = $urandom_range(0, 19);
            case (r)
                0: n_cfg = 0;
                1: n_cfg = 1024;
                2: n_cfg = 2047;
                3: n_cfg = 1;
                default: n_cfg = $urandom_range(2, 40);
            endcase
            n = (n_cfg == 0) ? 1 : (n_cfg > MAX_NODES ? MAX_NODES : n_cfg);
            add_ctl(CMD_CFG, n_cfg);
            if ($urandom_range(0, 4) == 0) add_ctl(CMD_DRAIN, 0);
            m = $urandom_range(1, (n > 20) ? 60 : 3 * n + 1);
            for (k = 0; k < m; k++) begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    s = $urandom_range(0, n - 1);
                    d = $urandom_range(0, n - 1);
                end else if (r < 9) begin
                    s = k % n;
                    d = (k + 1) % n;
                end else begin
                    s = $urandom_range(0, 1023);
                    d = $urandom_range(0, 1023);
                end
                add_edge(s, d);
            end
            pulls = (n > 40) ? $urandom_range(5, 40) : n + $urandom_range(0, 2);
            if ($urandom_range(0, 5) == 0) pulls = $urandom_range(1, pulls);
            add_pulls(pulls);
            items += m + pulls;
        end
        while (pending_cmds.size() != 0 || expected_vertices.size() != 0 || start)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
